FILE: sv/plsm_pkg.sv
// Package for the PHY link speed manager: phase codes, commands, register
// numbers, clock divider words and management frame builders.
// No dependencies.
package plsm_pkg;

    localparam int unsigned ADDR_W  = 5;
    localparam int unsigned DATA_W  = 16;
    localparam int unsigned FRAME_W = 31;
    localparam int unsigned CLK_W   = 25;
    localparam int unsigned PHASE_W = 4;

    typedef logic [FRAME_W-1:0] t_frame;
    typedef logic [CLK_W-1:0]   t_clk_word;

    localparam logic [1:0] CMD_START = 2'd0;
    localparam logic [1:0] CMD_DONE  = 2'd1;
    localparam logic [1:0] CMD_DELAY = 2'd2;

    localparam logic [PHASE_W-1:0] PH_IDLE      = 4'd0;
    localparam logic [PHASE_W-1:0] PH_AUTONEG   = 4'd1;
    localparam logic [PHASE_W-1:0] PH_CHECK     = 4'd2;
    localparam logic [PHASE_W-1:0] PH_DOWN_RD   = 4'd3;
    localparam logic [PHASE_W-1:0] PH_DOWN_WAIT = 4'd4;
    localparam logic [PHASE_W-1:0] PH_CTRL_RD   = 4'd5;
    localparam logic [PHASE_W-1:0] PH_GIG_RD    = 4'd6;
    localparam logic [PHASE_W-1:0] PH_UP_RD     = 4'd7;
    localparam logic [PHASE_W-1:0] PH_UP_WAIT   = 4'd8;

    localparam logic [ADDR_W-1:0] REG_CTRL    = 5'd0;
    localparam logic [ADDR_W-1:0] REG_STATUS  = 5'd1;
    localparam logic [ADDR_W-1:0] REG_GSTATUS = 5'd10;
    localparam logic [ADDR_W-1:0] REG_PHYCTRL = 5'h1f;

    localparam logic [DATA_W-1:0] BIT_AUTONEG = 16'h1000;
    localparam int unsigned       LINK_BIT    = 2;

    localparam t_clk_word CLK_1000 = t_clk_word'((1 << 20) | (8 << 8) | 1);
    localparam t_clk_word CLK_100  = t_clk_word'((5 << 20) | (8 << 8) | 1);
    localparam t_clk_word CLK_10   = t_clk_word'((20 << 20) | (20 << 8) | 1);

    localparam logic [1:0] SPD_10   = 2'd0;
    localparam logic [1:0] SPD_100  = 2'd1;
    localparam logic [1:0] SPD_1000 = 2'd2;

    localparam logic [2:0] APB_IDX_PHY_ADDR = 3'd0;

    function automatic t_frame f_read(input logic [ADDR_W-1:0] phy,
                                      input logic [ADDR_W-1:0] regn);
        t_frame w;
        w        = '0;
        w[30]    = 1'b1;
        w[29]    = 1'b1;
        w[27:23] = phy;
        w[22:18] = regn;
        w[17]    = 1'b1;
        return w;
    endfunction

    function automatic t_frame f_write(input logic [ADDR_W-1:0] phy,
                                       input logic [ADDR_W-1:0] regn,
                                       input logic [DATA_W-1:0] data);
        t_frame w;
        w        = '0;
        w[30]    = 1'b1;
        w[28]    = 1'b1;
        w[27:23] = phy;
        w[22:18] = regn;
        w[17]    = 1'b1;
        w[15:0]  = data;
        return w;
    endfunction

endpackage

FILE: sv/phy_link_speed_manager.sv
// Top level of the PHY link speed manager: phase machine, MAC settings,
// APB register and registered result stage. Depends on plsm_pkg.
//
// channel  | dir | handshake                  | payload
// s_axis   | in  | i_s_axis_tvalid/o_..tready | tuser command, tdata read_data
// m_axis   | out | o_m_axis_tvalid/i_..tready | tuser frame_valid, tdata status
// apb      | in  | i_psel/i_penable/o_pready  | phy_address at byte 0
//
// One request per cycle; its result appears in the cycle after acceptance,
// from the result register. The phase update is a single pass of logic between
// state registers. Input is stalled only while the result register is full
// and the sink holds off. Reset is synchronous; after reset the block is idle.
module phy_link_speed_manager (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [15:0] i_s_axis_tdata,   // [15:0] read_data
    input  logic [1:0]  i_s_axis_tuser,   // [1:0] command
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    // [30:0] frame_word, [31] delay_request, [32] link_up, [33] gigabit_enable,
    // [34] speed_select, [35] full_duplex, [60:36] clock_control,
    // [62:61] speed_code, [63] zero
    output logic [63:0] o_m_axis_tdata,
    output logic        o_m_axis_tuser,   // [0] frame_valid
    input  logic        i_psel,
    input  logic        i_penable,
    input  logic        i_pwrite,
    input  logic [2:0]  i_paddr,
    input  logic [31:0] i_pwdata,
    output logic [31:0] o_prdata,
    output logic        o_pready
);
    import plsm_pkg::*;

    logic [ADDR_W-1:0]  r_phy_addr;
    logic [PHASE_W-1:0] r_phase, n_phase;
    logic [3:0]         r_resolved, n_resolved;
    logic               r_link, n_link;
    logic               r_gig, n_gig;
    logic               r_speed, n_speed;
    logic               r_duplex, n_duplex;
    t_clk_word          r_clk, n_clk;
    logic [1:0]         r_spd, n_spd;

    logic               r_out_valid;
    logic               r_out_user, n_out_user;
    logic [63:0]        r_out_data, n_out_data;

    logic               s_accept;
    logic               s_apply;
    t_frame             s_frame;
    logic               s_delay;
    logic [DATA_W-1:0]  s_data;

    assign s_data          = i_s_axis_tdata;
    assign o_s_axis_tready = !r_out_valid || i_m_axis_tready;
    assign s_accept        = i_s_axis_tvalid && o_s_axis_tready;

    assign o_pready = 1'b1;
    assign o_prdata = (i_paddr[2] == APB_IDX_PHY_ADDR[0]) ?
                      {{(32-ADDR_W){1'b0}}, r_phy_addr} : 32'd0;

    always_comb begin
        n_phase    = r_phase;
        n_resolved = r_resolved;
        n_link     = r_link;
        n_gig      = r_gig;
        n_speed    = r_speed;
        n_duplex   = r_duplex;
        n_clk      = r_clk;
        n_spd      = r_spd;
        n_out_user = 1'b0;
        s_frame    = '0;
        s_apply    = 1'b0;
        case (i_s_axis_tuser)
            CMD_START: begin
                if (r_phase == PH_IDLE) begin
                    n_out_user = 1'b1;
                    s_frame    = f_write(r_phy_addr, REG_CTRL, BIT_AUTONEG);
                    n_phase    = PH_AUTONEG;
                end
            end
            CMD_DONE: begin
                case (r_phase)
                    PH_AUTONEG: begin
                        n_out_user = 1'b1;
                        s_frame    = f_read(r_phy_addr, REG_STATUS);
                        n_phase    = PH_CHECK;
                    end
                    PH_CHECK: begin
                        n_out_user = 1'b1;
                        if (!s_data[LINK_BIT]) begin
                            n_link  = 1'b0;
                            s_frame = f_read(r_phy_addr, REG_STATUS);
                            n_phase = PH_DOWN_RD;
                        end else begin
                            s_frame = f_read(r_phy_addr, REG_PHYCTRL);
                            n_phase = PH_CTRL_RD;
                        end
                    end
                    PH_DOWN_RD: begin
                        if (!s_data[LINK_BIT]) begin
                            n_phase = PH_DOWN_WAIT;
                        end else begin
                            n_out_user = 1'b1;
                            s_frame    = f_read(r_phy_addr, REG_PHYCTRL);
                            n_phase    = PH_CTRL_RD;
                        end
                    end
                    PH_CTRL_RD: begin
                        n_resolved = s_data[6:3];
                        if (s_data[6]) begin
                            n_out_user = 1'b1;
                            s_frame    = f_read(r_phy_addr, REG_GSTATUS);
                            n_phase    = PH_GIG_RD;
                        end else begin
                            s_apply = 1'b1;
                        end
                    end
                    PH_GIG_RD: begin
                        if (s_data[13:12] != 2'b11) begin
                            n_out_user = 1'b1;
                            s_frame    = f_read(r_phy_addr, REG_GSTATUS);
                        end else begin
                            s_apply = 1'b1;
                        end
                    end
                    PH_UP_RD: begin
                        if (s_data[LINK_BIT]) begin
                            n_phase = PH_UP_WAIT;
                        end else begin
                            n_out_user = 1'b1;
                            s_frame    = f_read(r_phy_addr, REG_STATUS);
                            n_phase    = PH_CHECK;
                        end
                    end
                    default: begin
                    end
                endcase
            end
            CMD_DELAY: begin
                if (r_phase == PH_DOWN_WAIT) begin
                    n_out_user = 1'b1;
                    s_frame    = f_read(r_phy_addr, REG_STATUS);
                    n_phase    = PH_DOWN_RD;
                end else if (r_phase == PH_UP_WAIT) begin
                    n_out_user = 1'b1;
                    s_frame    = f_read(r_phy_addr, REG_STATUS);
                    n_phase    = PH_UP_RD;
                end
            end
            default: begin
            end
        endcase

        if (s_apply) begin
            if (n_resolved[3]) begin
                n_gig = 1'b1;
                n_clk = CLK_1000;
                n_spd = SPD_1000;
            end else if (n_resolved[2]) begin
                n_gig   = 1'b0;
                n_speed = 1'b1;
                n_clk   = CLK_100;
                n_spd   = SPD_100;
            end else if (n_resolved[1]) begin
                n_gig   = 1'b0;
                n_speed = 1'b0;
                n_clk   = CLK_10;
                n_spd   = SPD_10;
            end
            n_duplex   = n_resolved[0];
            n_link     = 1'b1;
            n_out_user = 1'b1;
            s_frame    = f_read(r_phy_addr, REG_STATUS);
            n_phase    = PH_UP_RD;
        end

        s_delay    = (n_phase == PH_DOWN_WAIT) || (n_phase == PH_UP_WAIT);
        n_out_data = {1'b0, n_spd, n_clk, n_duplex, n_speed, n_gig, n_link,
                      s_delay, s_frame};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phy_addr <= '0;
        end else if (i_psel && i_penable && i_pwrite && o_pready &&
                     i_paddr[2] == APB_IDX_PHY_ADDR[0]) begin
            r_phy_addr <= i_pwdata[ADDR_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= PH_IDLE;
            r_resolved <= '0;
            r_link     <= 1'b0;
            r_gig      <= 1'b1;
            r_speed    <= 1'b1;
            r_duplex   <= 1'b1;
            r_clk      <= '0;
            r_spd      <= SPD_1000;
        end else if (s_accept) begin
            r_phase    <= n_phase;
            r_resolved <= n_resolved;
            r_link     <= n_link;
            r_gig      <= n_gig;
            r_speed    <= n_speed;
            r_duplex   <= n_duplex;
            r_clk      <= n_clk;
            r_spd      <= n_spd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s_accept) begin
            r_out_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_accept) begin
            r_out_user <= n_out_user;
            r_out_data <= n_out_data;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tuser  = r_out_user;
    assign o_m_axis_tdata  = r_out_data;

`ifndef SYNTH
    a_frame_form: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_user) |-> (r_out_data[30] && r_out_data[17]))
        else $error("issued frame lacks start or turnaround bits");
    a_no_frame_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_out_user) |-> (r_out_data[30:0] == '0))
        else $error("frame word not cleared without a frame");
    a_link_rise: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_link) |-> $past(s_accept) && (r_phase == PH_UP_RD))
        else $error("link flag raised outside settings update");
    a_phase_change: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !s_accept |=> $stable(r_phase))
        else $error("phase moved without a request");
`endif

endmodule
